@@ sv/bps_pkg.sv @@
// Package for the bitmap priority scheduler: request, result, command and
// status types, shared by the controller, datapath and top level.
// No dependencies.
package bps_pkg;

  localparam int MASK_W  = 32;
  localparam int PRIO_W  = 6;
  localparam int TIME_W  = 32;
  localparam int GROUP_W = 8;
  localparam int GROUPS  = MASK_W / GROUP_W;
  localparam int POS_W   = $clog2(GROUP_W);
  localparam int GRP_IDX_W = $clog2(GROUPS);

  typedef enum logic [1:0] {
    MODE_REGISTER = 2'd0,
    MODE_BLOCK    = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_RESCHED  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [PRIO_W-1:0]   priority_req;
    logic [TIME_W-1:0]   block_time;
  } req_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   next_priority;
    logic                switch_request;
    logic                rejected;
    logic [MASK_W-1:0]   ready_bits;
    logic [MASK_W-1:0]   blocked_bits;
  } res_t;

  typedef struct packed {
    logic accept;
    logic tick_step;
    logic pick;
    logic resched;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic tick_last;
    logic out_free;
  } status_t;

endpackage

@@ sv/bps_ctrl.sv @@
// Sequencing controller for the bitmap priority scheduler.
// Depends on bps_pkg for the command and status types.
module bps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bps_pkg::mode_t    mode,
  input  bps_pkg::status_t  status,
  output bps_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_PICK,
    S_SEL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          case (mode)
            bps_pkg::MODE_REGISTER: state_next = S_DONE;
            bps_pkg::MODE_TICK:     state_next = S_TICK;
            default:                state_next = S_PICK;
          endcase
        end
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (status.tick_last) state_next = S_DONE;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.resched = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = status.out_free;
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/bps_dp.sv @@
// Datapath of the bitmap priority scheduler: masks, countdown memory,
// two-stage priority pick and the output register. Depends on bps_pkg.
module bps_dp #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  bps_pkg::req_t     req,
  input  bps_pkg::cmd_t     cmd,
  output bps_pkg::status_t  status,
  output logic              out_valid,
  input  logic              out_ready,
  output bps_pkg::res_t     out_data
);

  localparam int IDX_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [bps_pkg::TIME_W-1:0] COUNT_MAX =
    bps_pkg::TIME_W'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PRIORITY_LEVELS - 1);

  logic [bps_pkg::MASK_W-1:0] ready_set;
  logic [bps_pkg::MASK_W-1:0] blocked_set;
  logic [PRIORITY_LEVELS-1:0] reg_mask;
  logic [bps_pkg::PRIO_W-1:0] running;
  logic                       running_valid;
  logic                       sw_flag;
  logic                       rej_flag;

  logic [COUNT_WIDTH-1:0] countdown [PRIORITY_LEVELS];
  logic [COUNT_WIDTH-1:0] rdata;
  logic [IDX_W-1:0]       scan_idx;

  logic [bps_pkg::GROUPS-1:0] grp_any;
  logic [bps_pkg::POS_W-1:0]  grp_pos [bps_pkg::GROUPS];
  logic [bps_pkg::GROUPS-1:0] grp_any_r;
  logic [bps_pkg::POS_W-1:0]  grp_pos_r [bps_pkg::GROUPS];
  logic [bps_pkg::PRIO_W-1:0] highest;

  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [COUNT_WIDTH-1:0]     mem_wdata;
  logic                       mem_re;
  logic [IDX_W-1:0]           mem_raddr;

  logic [IDX_W-1:0]           reg_idx;
  logic                       reg_rej;
  logic [IDX_W-1:0]           run_idx;
  logic                       blk_rej;
  logic [bps_pkg::TIME_W-1:0] blk_time;
  logic [COUNT_WIDTH-1:0]     blk_count;
  logic [bps_pkg::MASK_W-1:0] reg_bit;
  logic [bps_pkg::MASK_W-1:0] run_bit;
  logic [bps_pkg::MASK_W-1:0] scan_bit;
  logic                       scan_blocked;
  logic                       scan_expire;

  assign reg_idx = IDX_W'(req.priority_req - bps_pkg::PRIO_W'(1));
  assign reg_rej = (req.priority_req == '0) ||
                   (req.priority_req > bps_pkg::PRIO_W'(PRIORITY_LEVELS)) ||
                   (|(reg_mask & (PRIORITY_LEVELS'(1) << reg_idx)));
  assign reg_bit = bps_pkg::MASK_W'(1) << reg_idx;

  assign run_idx = IDX_W'(running - bps_pkg::PRIO_W'(1));
  assign blk_rej = (running == '0);
  assign run_bit = bps_pkg::MASK_W'(1) << run_idx;

  // A zero block time counts as one tick; wide times saturate to the counter.
  always_comb begin
    blk_time = (req.block_time == '0) ? bps_pkg::TIME_W'(1) : req.block_time;
    if (blk_time > COUNT_MAX) blk_time = COUNT_MAX;
    blk_count = COUNT_WIDTH'(blk_time);
  end

  assign scan_bit     = bps_pkg::MASK_W'(1) << scan_idx;
  assign scan_blocked = |(blocked_set & scan_bit);
  assign scan_expire  = (rdata <= COUNT_WIDTH'(1));

  assign status.tick_last = (scan_idx == LAST_IDX);
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_idx;
    mem_wdata = scan_expire ? '0 : rdata - COUNT_WIDTH'(1);
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (cmd.accept && req.mode == bps_pkg::MODE_BLOCK && !blk_rej) begin
      mem_we    = 1'b1;
      mem_waddr = run_idx;
      mem_wdata = blk_count;
    end
    if (cmd.accept && req.mode == bps_pkg::MODE_TICK) begin
      mem_re = 1'b1;
    end
    if (cmd.tick_step) begin
      mem_we = scan_blocked;
      if (!status.tick_last) begin
        mem_re    = 1'b1;
        mem_raddr = scan_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) countdown[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= countdown[mem_raddr];
  end

  // First pick stage: highest ready bit within each byte of the mask.
  always_comb begin
    for (int g = 0; g < bps_pkg::GROUPS; g++) begin
      grp_any[g] = |ready_set[g*bps_pkg::GROUP_W +: bps_pkg::GROUP_W];
      grp_pos[g] = '0;
      for (int b = 0; b < bps_pkg::GROUP_W; b++) begin
        if (ready_set[g*bps_pkg::GROUP_W + b]) grp_pos[g] = bps_pkg::POS_W'(b);
      end
    end
  end

  // Second pick stage: highest byte that holds a ready bit; idle if none.
  always_comb begin
    highest = '0;
    for (int g = 0; g < bps_pkg::GROUPS; g++) begin
      if (grp_any_r[g]) begin
        highest = bps_pkg::PRIO_W'({bps_pkg::GRP_IDX_W'(g), grp_pos_r[g]}) +
                  bps_pkg::PRIO_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      grp_any_r <= grp_any;
      for (int g = 0; g < bps_pkg::GROUPS; g++) grp_pos_r[g] <= grp_pos[g];
    end
    if (cmd.load_out) begin
      out_data.next_priority  <= running;
      out_data.switch_request <= sw_flag;
      out_data.rejected       <= rej_flag;
      out_data.ready_bits     <= ready_set;
      out_data.blocked_bits   <= blocked_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_set     <= '0;
      blocked_set   <= '0;
      reg_mask      <= '0;
      running       <= '0;
      running_valid <= 1'b0;
      sw_flag       <= 1'b0;
      rej_flag      <= 1'b0;
      scan_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        sw_flag  <= 1'b0;
        rej_flag <= 1'b0;
        scan_idx <= '0;
        case (req.mode)
          bps_pkg::MODE_REGISTER: begin
            if (reg_rej) begin
              rej_flag <= 1'b1;
            end else begin
              reg_mask  <= reg_mask | (PRIORITY_LEVELS'(1) << reg_idx);
              ready_set <= ready_set | reg_bit;
            end
          end
          bps_pkg::MODE_BLOCK: begin
            if (blk_rej) begin
              rej_flag <= 1'b1;
            end else begin
              ready_set   <= ready_set & ~run_bit;
              blocked_set <= blocked_set | run_bit;
            end
          end
          default: ;
        endcase
      end
      if (cmd.tick_step) begin
        if (scan_blocked && scan_expire) begin
          blocked_set <= blocked_set & ~scan_bit;
          ready_set   <= ready_set | scan_bit;
        end
        if (!status.tick_last) scan_idx <= scan_idx + IDX_W'(1);
      end
      // A refused block leaves the running thread in place.
      if (cmd.resched && !rej_flag) begin
        sw_flag       <= !running_valid || (highest != running);
        running       <= highest;
        running_valid <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/bitmap_priority_scheduler_unit.sv @@
// Top level of the bitmap priority scheduler: controller and datapath.
// Depends on bps_pkg, bps_ctrl and bps_dp.
//
// One request is handled at a time and gives one result. A register request
// goes from acceptance straight to the output register; a block or reschedule
// request passes the pick and select states (the highest ready priority is
// found in two registered stages, per byte and then across bytes), and a tick
// walks the countdown memory one entry per cycle through its single read port,
// with the decremented value written back behind the read. The output register
// lets the next request be taken while a result waits to be collected.
module bitmap_priority_scheduler_unit #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bps_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bps_pkg::res_t  out_data
);

  bps_pkg::cmd_t    cmd;
  bps_pkg::status_t status;

  bps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (in_data.mode),
    .status   (status),
    .cmd      (cmd)
  );

  bps_dp #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the bitmap priority scheduler top level.
// It predicts every result from its own copy of the scheduler state and
// depends only on bps_pkg and bitmap_priority_scheduler_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCHED_LEVELS = 32;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 40;

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  bps_pkg::req_t in_data = '0;
  logic in_ready;
  logic out_valid;
  bps_pkg::res_t out_data;

  bitmap_priority_scheduler_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Scheduler state as the testbench expects it to be.
  logic [31:0] ready_mask;
  logic [31:0] blocked_mask;
  logic [32:0] registered_mask;
  logic [31:0] tick_count [SCHED_LEVELS];
  logic [5:0]  running_prio;
  bit          running_known;

  bps_pkg::res_t sched_expect_q [$];
  bps_pkg::res_t want_res;

  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  int hold_token   = 0;
  int hold_seen    = 0;
  int sink_wait    = 0;
  int stuck_cycles = 0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int switches_seen  = 0;
  int refusals_seen  = 0;
  int mode_count [4] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Picks the highest ready priority and makes it the running one.
  function automatic void pick_next_thread(inout bps_pkg::res_t res);
    logic [5:0] next;
    next = '0;
    for (int i = 0; i < SCHED_LEVELS; i++) begin
      if (ready_mask[i]) next = 6'(i + 1);
    end
    res.switch_request = !running_known || (next != running_prio);
    running_prio = next;
    running_known = 1'b1;
    res.next_priority = next;
  endfunction

  function automatic bps_pkg::res_t predict_schedule(input bps_pkg::req_t r);
    bps_pkg::res_t res;
    logic [31:0] ticks;
    res = '0;
    res.next_priority = running_prio;
    case (r.mode)
      bps_pkg::MODE_REGISTER: begin
        if (r.priority_req > 6'(SCHED_LEVELS) || registered_mask[r.priority_req]) begin
          res.rejected = 1'b1;
        end else begin
          registered_mask[r.priority_req] = 1'b1;
          if (r.priority_req != '0) ready_mask[r.priority_req - 1] = 1'b1;
        end
      end
      bps_pkg::MODE_BLOCK: begin
        if (running_prio == '0) begin
          res.rejected = 1'b1;
        end else begin
          ticks = (r.block_time == '0) ? 32'd1 : r.block_time;
          tick_count[running_prio - 1] = ticks;
          ready_mask[running_prio - 1] = 1'b0;
          blocked_mask[running_prio - 1] = 1'b1;
          pick_next_thread(res);
        end
      end
      bps_pkg::MODE_TICK: begin
        for (int i = 0; i < SCHED_LEVELS; i++) begin
          if (blocked_mask[i]) begin
            if (tick_count[i] <= 32'd1) begin
              tick_count[i] = '0;
              blocked_mask[i] = 1'b0;
              ready_mask[i] = 1'b1;
            end else begin
              tick_count[i] = tick_count[i] - 32'd1;
            end
          end
        end
      end
      default: begin
        pick_next_thread(res);
      end
    endcase
    res.ready_bits = ready_mask;
    res.blocked_bits = blocked_mask;
    return res;
  endfunction

  function automatic bps_pkg::req_t make_req(input bps_pkg::mode_t m, input logic [5:0] p,
                                             input logic [31:0] t);
    bps_pkg::req_t r;
    r.mode = m;
    r.priority_req = p;
    r.block_time = t;
    return r;
  endfunction

  function automatic bps_pkg::req_t random_request();
    bps_pkg::req_t r;
    int pick;
    int span;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 99);
    r.priority_req = 6'($urandom_range(0, 63));
    r.block_time = $urandom();
    if (pick < 15) begin
      r.mode = bps_pkg::MODE_REGISTER;
      if (span < 70) r.priority_req = 6'($urandom_range(1, SCHED_LEVELS));
    end else if (pick < 45) begin
      r.mode = bps_pkg::MODE_BLOCK;
      // Mostly short blocks so that threads come back; a rare wide one parks a
      // priority for good.
      if (span < 60) r.block_time = $urandom_range(0, 3);
      else if (span < 97) r.block_time = $urandom_range(4, 40);
    end else if (pick < 80) begin
      r.mode = bps_pkg::MODE_TICK;
    end else begin
      r.mode = bps_pkg::MODE_RESCHED;
    end
    return r;
  endfunction

  task automatic send_request(input bps_pkg::req_t r);
    int gap;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    sched_expect_q.push_back(predict_schedule(r));
    mode_count[int'(r.mode)]++;
    gap = (src_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("Mismatch at result %0d: %s, expected %h, got %h",
             results_seen, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_data.switch_request) switches_seen++;
      if (out_data.rejected) refusals_seen++;
      if (sched_expect_q.size() == 0) begin
        report_mismatch("result with no request pending", '0, out_data.ready_bits);
      end else begin
        want_res = sched_expect_q.pop_front();
        if (out_data.next_priority !== want_res.next_priority)
          report_mismatch("next_priority", 32'(want_res.next_priority),
                          32'(out_data.next_priority));
        if (out_data.switch_request !== want_res.switch_request)
          report_mismatch("switch_request", 32'(want_res.switch_request),
                          32'(out_data.switch_request));
        if (out_data.rejected !== want_res.rejected)
          report_mismatch("rejected", 32'(want_res.rejected), 32'(out_data.rejected));
        if (out_data.ready_bits !== want_res.ready_bits)
          report_mismatch("ready_bits", want_res.ready_bits, out_data.ready_bits);
        if (out_data.blocked_bits !== want_res.blocked_bits)
          report_mismatch("blocked_bits", want_res.blocked_bits, out_data.blocked_bits);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        sink_wait = HOLD_CYCLES;
      end
      if (sink_wait > 0) begin
        out_ready <= 1'b0;
        sink_wait--;
      end else begin
        out_ready <= 1'b1;
        if (sink_idle_en && $urandom_range(0, 4) == 0) sink_wait = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", STUCK_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Rescheduling with nothing registered, and a block while only idle runs.
  task automatic test_idle_start();
    send_request(make_req(bps_pkg::MODE_RESCHED, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_BLOCK, 6'd0, 32'd5));
  endtask

  // Idle and out-of-range priorities are refused, as is a second registration.
  task automatic test_registration();
    send_request(make_req(bps_pkg::MODE_REGISTER, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_REGISTER, 6'd33, 32'd0));
    send_request(make_req(bps_pkg::MODE_REGISTER, 6'd63, 32'hFFFF_FFFF));
    send_request(make_req(bps_pkg::MODE_REGISTER, 6'd32, 32'd0));
    send_request(make_req(bps_pkg::MODE_REGISTER, 6'd32, 32'd0));
    send_request(make_req(bps_pkg::MODE_REGISTER, 6'd1, 32'd0));
  endtask

  task automatic test_block_release();
    send_request(make_req(bps_pkg::MODE_TICK, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_RESCHED, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_RESCHED, 6'd0, 32'd0));
    // A zero block time still parks the thread for one tick.
    send_request(make_req(bps_pkg::MODE_BLOCK, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_TICK, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_RESCHED, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_BLOCK, 6'd0, 32'd3));
    send_request(make_req(bps_pkg::MODE_REGISTER, 6'd17, 32'd0));
    send_request(make_req(bps_pkg::MODE_RESCHED, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_BLOCK, 6'd0, 32'hFFFF_FFFF));
    send_request(make_req(bps_pkg::MODE_BLOCK, 6'd0, 32'd2));
    // Everything left is blocked, so idle runs and a block is refused again.
    send_request(make_req(bps_pkg::MODE_BLOCK, 6'd0, 32'd1));
    send_request(make_req(bps_pkg::MODE_TICK, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_TICK, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_TICK, 6'd0, 32'd0));
    send_request(make_req(bps_pkg::MODE_RESCHED, 6'd0, 32'd0));
  endtask

  task automatic test_random_traffic(input int count);
    src_idle_en = 1'b1;
    sink_idle_en <= 1'b1;
    repeat (count) send_request(random_request());
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure(input int count);
    src_idle_en = 1'b0;
    hold_token <= hold_token + 1;
    repeat (count) send_request(random_request());
  endtask

  task automatic test_back_to_back(input int count);
    src_idle_en = 1'b0;
    sink_idle_en <= 1'b0;
    repeat (count) send_request(random_request());
  endtask

  initial begin
    ready_mask = '0;
    blocked_mask = '0;
    registered_mask = 33'd1;
    running_prio = '0;
    running_known = 1'b0;
    for (int i = 0; i < SCHED_LEVELS; i++) tick_count[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_idle_start();
    test_registration();
    test_block_release();
    test_random_traffic(300);
    test_backpressure(30);
    test_back_to_back(70);
    test_random_traffic(300);

    in_valid <= 1'b0;
    do @(posedge clk); while (sched_expect_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sched_expect_q.size() != 0)
      report_mismatch("requests left without a result", '0, sched_expect_q.size());

    $display("Sent %0d register, %0d block, %0d tick and %0d reschedule requests.",
             mode_count[int'(bps_pkg::MODE_REGISTER)], mode_count[int'(bps_pkg::MODE_BLOCK)],
             mode_count[int'(bps_pkg::MODE_TICK)], mode_count[int'(bps_pkg::MODE_RESCHED)]);
    $display("Checked %0d results (%0d switches, %0d refusals), %0d mismatches.",
             results_seen, switches_seen, refusals_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
